>>> rtl/vsnc_pkg.sv
// Package for the sample noise counter: parse phases, character codes,
// and the structs passed between the scanner and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vsnc_pkg;

  localparam int FieldWidth = 32;
  localparam int CountWidthDefault = 32;
  localparam int ColumnWidth = 4;
  localparam int LevelWidth = 2;

  localparam logic [ColumnWidth-1:0] SAMPLE_COLUMN = 4'd9;

  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [LevelWidth-1:0] LEVEL_MAX = 2'd2;

  typedef enum logic [2:0] {
    PH_OUTSIDE,
    PH_FIRST,
    PH_COLON,
    PH_COMMA,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic [ColumnWidth-1:0] column;
    phase_t                 phase;
    logic [LevelWidth-1:0]  level;
  } line_state_t;

  typedef struct packed {
    logic clear;
    logic total_inc;
    logic noise_inc;
    logic noise2_inc;
    logic line_end;
  } scan_event_t;

endpackage

`default_nettype wire

>>> rtl/vsnc_if.sv
// Valid/ready channel interfaces for the sample noise counter.
// Depends on vsnc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vsnc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] text_byte;

  modport source (output valid, output command, output text_byte, input ready);
  modport sink (input valid, input command, input text_byte, output ready);
endinterface

interface vsnc_out_if;
  logic                           valid;
  logic                           ready;
  logic [vsnc_pkg::FieldWidth-1:0] sample_total;
  logic [vsnc_pkg::FieldWidth-1:0] noise_count;
  logic [vsnc_pkg::FieldWidth-1:0] noise2_count;
  logic                           line_end;

  modport source (output valid, output sample_total, output noise_count,
                  output noise2_count, output line_end, input ready);
  modport sink (input valid, input sample_total, input noise_count,
                input noise2_count, input line_end, output ready);
endinterface

`default_nettype wire

>>> rtl/vcf_sample_noise_counter.sv
// A result beat becomes valid in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the input is taken whenever the
// result register is empty or its beat is being taken in the same cycle.
// Reset (rst_n low, synchronous) clears the counters, the line parse state
// and the result register; no result is pending after reset.
// Depends on vsnc_pkg, vsnc_if and vsnc_scan.
`timescale 1ns / 1ps
`default_nettype none

module vcf_sample_noise_counter #(
  parameter int COUNT_WIDTH = vsnc_pkg::CountWidthDefault
) (
  input wire logic clk,
  input wire logic rst_n,
  vsnc_in_if.sink  in_ch,
  vsnc_out_if.source out_ch
);
  import vsnc_pkg::*;

  // Line parse state: column, phase and digit level.
  line_state_t state_r;
  line_state_t state_nxt;
  scan_event_t events;

  // Running counters, COUNT_WIDTH bits, wrapping.
  logic [COUNT_WIDTH-1:0] total_r;
  logic [COUNT_WIDTH-1:0] noise_r;
  logic [COUNT_WIDTH-1:0] noise2_r;
  logic [COUNT_WIDTH-1:0] total_nxt;
  logic [COUNT_WIDTH-1:0] noise_nxt;
  logic [COUNT_WIDTH-1:0] noise2_nxt;

  // Result register.
  logic out_valid_r;
  logic line_end_r;
  logic in_accept;

  // The result register is free when empty or when its beat leaves now,
  // so a stalled result never blocks the cycle that drains it.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  vsnc_scan u_scan (
    .command   (in_ch.command),
    .text_byte (in_ch.text_byte),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .events    (events)
  );

  // A clear command zeroes every counter; otherwise each counter moves by
  // at most one per byte.
  always_comb begin
    if (events.clear) begin
      total_nxt  = '0;
      noise_nxt  = '0;
      noise2_nxt = '0;
    end else begin
      total_nxt  = total_r + COUNT_WIDTH'(events.total_inc);
      noise_nxt  = noise_r + COUNT_WIDTH'(events.noise_inc);
      noise2_nxt = noise2_r + COUNT_WIDTH'(events.noise2_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{column: '0, phase: PH_OUTSIDE, level: '0};
      total_r     <= '0;
      noise_r     <= '0;
      noise2_r    <= '0;
      out_valid_r <= 1'b0;
      line_end_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r     <= state_nxt;
        total_r     <= total_nxt;
        noise_r     <= noise_nxt;
        noise2_r    <= noise2_nxt;
        line_end_r  <= events.line_end;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The counters themselves hold the result fields: they change only on
  // an accepted beat, which also reloads the result register.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_total = FieldWidth'(total_r);
  assign out_ch.noise_count  = FieldWidth'(noise_r);
  assign out_ch.noise2_count = FieldWidth'(noise2_r);
  assign out_ch.line_end     = line_end_r;

`ifndef SYNTHESIS
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_ch.command == CMD_CLEAR |=>
      out_valid_r && total_r == '0 && noise_r == '0 && noise2_r == '0 && !line_end_r)
    else $error("clear beat did not zero the counters");

  a_sample_column: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase != PH_OUTSIDE |-> state_r.column == SAMPLE_COLUMN)
    else $error("sample parse active before the sample columns");

  a_line_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_ch.command == CMD_SCAN &&
      (in_ch.text_byte == CH_NUL || in_ch.text_byte == CH_NEWLINE) |=>
      state_r.column == '0 && state_r.phase == PH_OUTSIDE && line_end_r)
    else $error("line end did not reset the line state");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with an empty result register");

  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(total_r) && $stable(noise_r) && $stable(noise2_r))
    else $error("counters moved without an accepted beat");
`endif

endmodule

`default_nettype wire

>>> rtl/vsnc_scan.sv
// Per-byte line scanner: next column, phase and digit level, plus the
// counter events one byte causes. Depends on vsnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsnc_scan (
  input  wire logic                  command,
  input  wire logic [7:0]            text_byte,
  input  wire vsnc_pkg::line_state_t state_cur,
  output vsnc_pkg::line_state_t      state_nxt,
  output vsnc_pkg::scan_event_t      events
);
  import vsnc_pkg::*;

  always_comb begin
    logic [ColumnWidth-1:0] col_sat;
    phase_t                 ph;
    logic [7:0]             digit;

    state_nxt = state_cur;
    events    = '0;
    col_sat   = state_cur.column;
    ph        = state_cur.phase;
    digit     = text_byte - CH_ZERO;

    if (command == CMD_CLEAR) begin
      state_nxt    = '{column: '0, phase: PH_OUTSIDE, level: '0};
      events.clear = 1'b1;
    end else if (text_byte == CH_NUL || text_byte == CH_NEWLINE) begin
      events.noise_inc = (state_cur.phase == PH_FIRST);
      events.line_end  = 1'b1;
      state_nxt        = '{column: '0, phase: PH_OUTSIDE, level: '0};
    end else if (text_byte == CH_TAB) begin
      events.noise_inc = (state_cur.phase == PH_FIRST);
      if (state_cur.column < SAMPLE_COLUMN) begin
        col_sat = state_cur.column + 1'b1;
      end
      state_nxt.column = col_sat;
      if (col_sat >= SAMPLE_COLUMN) begin
        events.total_inc = 1'b1;
        state_nxt.phase  = PH_FIRST;
        state_nxt.level  = '0;
      end else begin
        state_nxt.phase = PH_OUTSIDE;
      end
    end else begin
      // The first byte of a sample decides noise; a noise byte then falls through to
      // the colon search on the same byte.
      if (ph == PH_FIRST) begin
        if (text_byte == CH_DOT) begin
          ph = PH_OUTSIDE;
        end else begin
          events.noise_inc = 1'b1;
          ph = PH_COLON;
        end
      end
      state_nxt.phase = ph;
      case (ph)
        PH_COLON: begin
          if (text_byte == CH_COLON) begin
            state_nxt.phase = PH_COMMA;
          end
        end
        PH_COMMA: begin
          if (text_byte == CH_COLON) begin
            state_nxt.phase = PH_OUTSIDE;
          end else if (text_byte == CH_COMMA) begin
            state_nxt.phase = PH_DIGITS;
            state_nxt.level = '0;
          end
        end
        PH_DIGITS: begin
          if (text_byte >= CH_ZERO && text_byte <= CH_NINE) begin
            // The level is 0 or 1 here; any nonzero level times ten saturates.
            if (state_cur.level != '0 || digit >= 8'(LEVEL_MAX)) begin
              state_nxt.level   = LEVEL_MAX;
              state_nxt.phase   = PH_OUTSIDE;
              events.noise2_inc = 1'b1;
            end else begin
              state_nxt.level = LevelWidth'(digit);
            end
          end else begin
            state_nxt.phase = PH_OUTSIDE;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
